// ===== design/lscm_pkg.sv =====
// Shared types, constants and tables for the log spiral coordinate map.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps

package lscm_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int DATA_W        = 32;

  // mantissa of x*x+y*y in Q30, one log cell per fraction bit
  localparam int MANT_W    = 31;
  localparam int FRAC_W    = 30;
  localparam int LOG_STEPS = FRAC_W;
  localparam int EXP_W     = 6;
  localparam int SQ_W      = 64;

  // CORDIC datapath: inputs pre-scaled by 2^16, angle in Q30
  localparam int XW       = 52;
  localparam int ZW       = 33;
  localparam int PHI_W    = FRAC_BITS + 4;
  localparam int STG_IDX_W = 5;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_Y = 2'd1;

  localparam logic [30:0]          LN2_Q30        = 31'd744261118;
  localparam logic signed [ZW-1:0] HALF_PI_Q30    = 33'sd1686629713;
  localparam logic [28:0]          RECIP_TURN_Q30 = 29'd170896359;

  localparam longint INV_FULL = -64'sd1000 * (64'sd1 <<< FRAC_BITS);
  localparam logic signed [DATA_W-1:0] INVALID_COORD =
    (INV_FULL < -64'sd2147483648) ? 32'sh8000_0000 : INV_FULL[DATA_W-1:0];
  localparam logic signed [10:0] INVALID_FLAG = -11'sd1000;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_vec_t;

  typedef struct packed {
    logic [MANT_W-1:0] m;
    logic [FRAC_W-1:0] frac;
    logic [EXP_W-1:0]  expo;
  } log_vec_t;

  typedef struct packed {
    logic pix_vld;
    logic parity;
    logic zero;
  } side_t;

  // atan(2^-i) in Q30
  function automatic logic signed [ZW-1:0] atan_q30(input logic [STG_IDX_W-1:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:  a = 33'sd843314857;
      5'd1:  a = 33'sd497837829;
      5'd2:  a = 33'sd263043837;
      5'd3:  a = 33'sd133525159;
      5'd4:  a = 33'sd67021687;
      5'd5:  a = 33'sd33543516;
      5'd6:  a = 33'sd16775851;
      5'd7:  a = 33'sd8388437;
      5'd8:  a = 33'sd4194283;
      5'd9:  a = 33'sd2097149;
      5'd10: a = 33'sd1048576;
      5'd11: a = 33'sd524288;
      5'd12: a = 33'sd262144;
      5'd13: a = 33'sd131072;
      5'd14: a = 33'sd65536;
      5'd15: a = 33'sd32768;
      5'd16: a = 33'sd16384;
      5'd17: a = 33'sd8192;
      5'd18: a = 33'sd4096;
      5'd19: a = 33'sd2048;
      5'd20: a = 33'sd1024;
      5'd21: a = 33'sd512;
      5'd22: a = 33'sd256;
      5'd23: a = 33'sd128;
      5'd24: a = 33'sd64;
      5'd25: a = 33'sd32;
      5'd26: a = 33'sd16;
      5'd27: a = 33'sd8;
      5'd28: a = 33'sd4;
      5'd29: a = 33'sd2;
      5'd30: a = 33'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== design/lscm_cordic_cell.sv =====
// One CORDIC vectoring iteration with its output register.
// Depends on lscm_pkg.
`timescale 1ns / 1ps

module lscm_cordic_cell (
  input  logic                               clk,
  input  logic                               en,
  input  logic [lscm_pkg::STG_IDX_W-1:0]     stage_idx,
  input  lscm_pkg::cordic_vec_t              vec_in,
  output lscm_pkg::cordic_vec_t              vec_out
);
  import lscm_pkg::*;

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] da;
  cordic_vec_t          vec_nxt;
  cordic_vec_t          vec_r;

  // stage_idx is tied per instance, so the shifts fold to wiring
  assign dx = $signed(vec_in.y) >>> stage_idx;
  assign dy = $signed(vec_in.x) >>> stage_idx;
  assign da = atan_q30(stage_idx);

  always_comb begin
    if ($signed(vec_in.y) > 0) begin
      vec_nxt.x = $signed(vec_in.x) + dx;
      vec_nxt.y = $signed(vec_in.y) - dy;
      vec_nxt.z = $signed(vec_in.z) + da;
    end else begin
      vec_nxt.x = $signed(vec_in.x) - dx;
      vec_nxt.y = $signed(vec_in.y) + dy;
      vec_nxt.z = $signed(vec_in.z) - da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vec_out = vec_r;

endmodule

// ===== design/lscm_log_cell.sv =====
// One repeated-squaring step of the log2 fraction, with its output register.
// Depends on lscm_pkg.
`timescale 1ns / 1ps

module lscm_log_cell (
  input  logic                 clk,
  input  logic                 en,
  input  lscm_pkg::log_vec_t   vec_in,
  output lscm_pkg::log_vec_t   vec_out
);
  import lscm_pkg::*;

  logic [2*MANT_W-1:0] sq;
  logic [2*MANT_W-31:0] t;
  log_vec_t            vec_nxt;
  log_vec_t            vec_r;

  assign sq = vec_in.m * vec_in.m;
  assign t  = sq[2*MANT_W-1:30];

  // square >= 2.0 sets this fraction bit and renormalizes
  always_comb begin
    vec_nxt.expo = vec_in.expo;
    vec_nxt.frac = {vec_in.frac[FRAC_W-2:0], t[MANT_W]};
    vec_nxt.m    = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vec_out = vec_r;

endmodule

// ===== design/log_spiral_coordinate_map.sv =====
// Log spiral coordinate map: top level with front end, CORDIC and log cell rows, output math.
// Depends on lscm_pkg, lscm_cordic_cell and lscm_log_cell.
// Throughput: one request per clock; the 40-stage pipeline advances as a whole
// and holds while a result waits at the output register.
// Reset clears the valid bits and both period registers; no clearing pass.
`timescale 1ns / 1ps

module log_spiral_coordinate_map (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [71:0]                       in_tdata,  // in_x, in_y, parity, 7'b0
  input  logic                              in_tuser,  // pixel_valid
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [79:0]                       out_tdata, // out_x, out_y, out_flag, 5'b0
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lscm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lscm_pkg::DATA_W-1:0]       cfg_data
);
  import lscm_pkg::*;

  localparam int NSTG     = LOG_STEPS + 10;
  localparam int SIDE_LEN = NSTG - 2;
  localparam int PHI_DLY  = LOG_STEPS + 4 - CORDIC_STAGES;

  logic en;
  logic [NSTG-1:0] vld_r;

  // config
  logic signed [DATA_W-1:0] per_x_r, per_y_r;
  logic signed [DATA_W-1:0] px_r, py_r, px_nxt, py_nxt;
  logic signed [63:0]       pxm, pym;

  // stage 1
  logic signed [DATA_W-1:0] x1_r, y1_r;
  logic                     pv1_r, par1_r;

  // log front end
  logic signed [SQ_W-1:0] sqx_r, sqy_r;
  logic [SQ_W-1:0]        r2_r, r2_4_r, r2_sh;
  logic [EXP_W-1:0]       p_enc, p4_r;
  log_vec_t               log_chain [0:LOG_STEPS];

  // log back end
  logic [59:0]              fprod_r;
  logic signed [EXP_W:0]    e_int;
  logic signed [37:0]       iterm_r;
  logic signed [39:0]       lnq;
  logic signed [DATA_W-1:0] lnr_r;

  // CORDIC
  cordic_vec_t          cv0_nxt;
  cordic_vec_t          cord_chain [0:CORDIC_STAGES];
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] zr;
  logic signed [PHI_W-1:0] phi_r;
  logic signed [PHI_W-1:0] phi_d [0:PHI_DLY-1];

  side_t side_d [0:SIDE_LEN-1];

  // output math
  logic signed [PHI_W-1:0]  phi_e;
  logic signed [DATA_W-1:0] lnr_e;
  logic signed [63:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [63:0] sum_x_r, sum_y_r;
  logic signed [63:0] rx, ry;
  logic signed [DATA_W-1:0] out_x_r, out_y_r, out_x_nxt, out_y_nxt;
  logic signed [10:0] out_flag_r, out_flag_nxt;

  assign en        = !vld_r[NSTG-1] || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_x_r <= '0;
      per_y_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PERIOD_X: per_x_r <= cfg_data;
        CFG_PERIOD_Y: per_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // period / 6.283, settles long before a new request reaches the output math
  assign pxm    = per_x_r * $signed({35'd0, RECIP_TURN_Q30});
  assign pym    = per_y_r * $signed({35'd0, RECIP_TURN_Q30});
  assign px_nxt = DATA_W'((pxm + (64'sd1 <<< 29)) >>> 30);
  assign py_nxt = DATA_W'((pym + (64'sd1 <<< 29)) >>> 30);

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
  end

  // ---------------- stage 1: input register ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= in_tdata[31:0];
      y1_r   <= in_tdata[63:32];
      par1_r <= in_tdata[64];
      pv1_r  <= in_tuser;
    end
  end

  // ---------------- side-band shift line ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= '{pix_vld: pv1_r, parity: par1_r, zero: (x1_r == '0) && (y1_r == '0)};
      for (int i = 1; i < SIDE_LEN; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  // ---------------- log2 front end ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r  <= x1_r * x1_r;
      sqy_r  <= y1_r * y1_r;
      r2_r   <= $unsigned(sqx_r) + $unsigned(sqy_r);
      r2_4_r <= r2_r;
      p4_r   <= p_enc;
    end
  end

  always_comb begin
    p_enc = '0;
    for (int i = 0; i < SQ_W; i++) begin
      if (r2_r[i]) p_enc = EXP_W'(i);
    end
  end

  // normalize so the leading one lands at bit 30
  assign r2_sh = (p4_r >= 6'd30) ? (r2_4_r >> (p4_r - 6'd30)) : (r2_4_r << (6'd30 - p4_r));

  always_ff @(posedge clk) begin
    if (en) begin
      log_chain[0].m    <= r2_sh[MANT_W-1:0];
      log_chain[0].frac <= '0;
      log_chain[0].expo <= p4_r;
    end
  end

  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
    lscm_log_cell u_cell (
      .clk     (clk),
      .en      (en),
      .vec_in  (log_chain[g]),
      .vec_out (log_chain[g+1])
    );
  end

  assign e_int = $signed({1'b0, log_chain[LOG_STEPS].expo}) - 7'(2 * FRAC_BITS);

  // ln(r^2) = int*LN2 + frac*LN2, then halved and rounded
  assign lnq = 40'(iterm_r) + $signed({10'd0, fprod_r[59:30]});

  always_ff @(posedge clk) begin
    if (en) begin
      fprod_r <= log_chain[LOG_STEPS].frac * LN2_Q30;
      iterm_r <= e_int * $signed({1'b0, LN2_Q30});
      lnr_r   <= DATA_W'((lnq + (40'sd1 <<< (30 - FRAC_BITS))) >>> (31 - FRAC_BITS));
    end
  end

  // ---------------- CORDIC ----------------
  assign xs = {{(XW-DATA_W-16){x1_r[DATA_W-1]}}, x1_r, 16'd0};
  assign ys = {{(XW-DATA_W-16){y1_r[DATA_W-1]}}, y1_r, 16'd0};

  // left half plane: rotate by +/- 90 degrees first
  always_comb begin
    cv0_nxt.x = xs;
    cv0_nxt.y = ys;
    cv0_nxt.z = '0;
    if (x1_r < 0) begin
      if (y1_r >= 0) begin
        cv0_nxt.x = ys;
        cv0_nxt.y = -xs;
        cv0_nxt.z = HALF_PI_Q30;
      end else begin
        cv0_nxt.x = -ys;
        cv0_nxt.y = xs;
        cv0_nxt.z = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cord_chain[0] <= cv0_nxt;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    lscm_cordic_cell u_cell (
      .clk       (clk),
      .en        (en),
      .stage_idx (STG_IDX_W'(g)),
      .vec_in    (cord_chain[g]),
      .vec_out   (cord_chain[g+1])
    );
  end

  assign zr = $signed(cord_chain[CORDIC_STAGES].z) + (33'sd1 <<< (29 - FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      phi_r    <= PHI_W'(zr >>> (30 - FRAC_BITS));
      phi_d[0] <= phi_r;
      for (int i = 1; i < PHI_DLY; i++) begin
        phi_d[i] <= phi_d[i-1];
      end
    end
  end

  // ---------------- output math ----------------
  // zero radius: angle 0, log at the 32-bit minimum
  assign phi_e = side_d[SIDE_LEN-3].zero ? '0 : phi_d[PHI_DLY-1];
  assign lnr_e = side_d[SIDE_LEN-3].zero ? 32'sh8000_0000 : lnr_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r    <= 64'(phi_e) * 64'(px_r);
      pb_r    <= 64'(lnr_e) * 64'(py_r);
      pc_r    <= 64'(phi_e) * 64'(py_r);
      pd_r    <= 64'(lnr_e) * 64'(px_r);
      sum_x_r <= pa_r - pb_r;
      sum_y_r <= pc_r + pd_r;
    end
  end

  assign rx = (sum_x_r + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign ry = (sum_y_r + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  always_comb begin
    if (rx > 64'sd2147483647)       out_x_nxt = 32'sh7FFF_FFFF;
    else if (rx < -64'sd2147483648) out_x_nxt = 32'sh8000_0000;
    else                            out_x_nxt = rx[DATA_W-1:0];
    if (ry > 64'sd2147483647)       out_y_nxt = 32'sh7FFF_FFFF;
    else if (ry < -64'sd2147483648) out_y_nxt = 32'sh8000_0000;
    else                            out_y_nxt = ry[DATA_W-1:0];
    out_flag_nxt = {10'd0, side_d[SIDE_LEN-1].parity};
    if (!side_d[SIDE_LEN-1].pix_vld) begin
      out_x_nxt    = INVALID_COORD;
      out_y_nxt    = INVALID_COORD;
      out_flag_nxt = INVALID_FLAG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r    <= out_x_nxt;
      out_y_r    <= out_y_nxt;
      out_flag_r <= out_flag_nxt;
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {5'd0, out_flag_r, out_y_r, out_x_r};

  // ---------------- assertions ----------------
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_invalid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_flag_r == INVALID_FLAG) |->
      (out_x_r == INVALID_COORD && out_y_r == INVALID_COORD))
    else $error("invalid pixel without fill coordinates");

  a_flag_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_flag_r == INVALID_FLAG || out_flag_r == 11'sd0 ||
                    out_flag_r == 11'sd1))
    else $error("flag outside parity or invalid mark");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(vld_r) && $stable(out_x_r))
    else $error("pipeline moved during stall");

endmodule
